// ===== sv/tldc_pkg.sv =====
// Package for the trajectory line deviation cost block.
// Holds widths, limits and the shared operation codes; no dependencies.
`timescale 1ns / 1ps
package tldc_pkg;
    localparam int COORD_W  = 32;
    localparam int IDX_W    = 8;
    localparam int DEPTH    = 256;
    localparam int CNT_W    = 9;
    localparam int RAD_W    = 31;
    localparam int DIR_W    = 18;
    localparam int SUM_W    = 48;
    localparam int COST_W   = 47;
    localparam int WIDE_W   = 64;
    localparam logic [SUM_W-1:0]  SUM_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [COST_W-1:0] COST_MAX = 47'h7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] PROG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] PROG_MIN = 48'sh8000_0000_0000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic [0:0] REG_COUNT  = 1'b0;
    localparam logic [0:0] REG_RADIUS = 1'b1;

    typedef struct packed {
        logic start_sqrt;
        logic start_div;
    } unit_ctl_t;
endpackage

// ===== sv/trajectory_line_deviation_cost_core.sv =====
// Top level of the trajectory line deviation cost block: sequencer, table and sums.
// Depends on tldc_pkg, tldc_sqrt, tldc_div and tldc_mul.
//
//  channel   | dir | content (lowest bits first)
//  s_axis    | in  | tuser=op, tdata=entry_index,pos_x,pos_y,first_point,last_point
//  m_axis    | out | tdata=cost,segment_end
//  apb       | in  | waypoint_count @0, arrival_radius @4
//
// A point keeps the block busy through the shared 32-step square root (one or two runs)
// and the 48-step divider (two runs on a first point), plus the normalize shifts on a
// first point.
// Reset clears control, direction, previous point and sums, and sets the segment index to 1.
// s_axis_tready stays low while a request is in work or its result waits.
`timescale 1ns / 1ps
module trajectory_line_deviation_cost_core
    import tldc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // entry_index, pos_x, pos_y, first_point, last_point
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // cost, segment_end
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_ARR, ST_SEG, ST_NORM, ST_LEN, ST_LENW, ST_DX, ST_DXW,
        ST_DY, ST_DYW, ST_W, ST_DEV1, ST_DEV2, ST_DEVH, ST_DEVHW, ST_TRV, ST_TRVW,
        ST_PR1, ST_PR2, ST_SUM, ST_OUT
    } state_t;

    localparam logic [2:0] MS_WX_DY = 3'd0;
    localparam logic [2:0] MS_WY_DX = 3'd1;
    localparam logic [2:0] MS_EX_DX = 3'd2;
    localparam logic [2:0] MS_EY_DY = 3'd3;
    localparam logic [2:0] MS_NONE  = 3'd4;

    state_t state_reg;
    logic [COORD_W-1:0] path_x [DEPTH];
    logic [COORD_W-1:0] path_y [DEPTH];
    logic signed [COORD_W-1:0] rx0_reg, ry0_reg, rx1_reg, ry1_reg;
    logic [CNT_W-1:0] count_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [IDX_W-1:0] seg_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, prev_x_reg, prev_y_reg;
    logic first_reg, last_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg;
    logic [SUM_W-1:0] dev_reg, trv_reg;
    logic signed [SUM_W-1:0] prog_reg;
    logic [31:0] a_reg, b_reg;
    logic [5:0]  sh_reg;
    logic [31:0] len_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic m_valid_reg;

    logic [IDX_W-1:0] limit;
    logic [63:0] sq_in;
    logic        sq_done, dv_done;
    logic [31:0] sq_root;
    logic [SUM_W-1:0] dv_q, dv_in;
    unit_ctl_t ctl;
    logic signed [45:0] mul_a;
    logic signed [DIR_W-1:0] mul_b;
    logic signed [WIDE_W-1:0] mul_p;
    logic [2:0] msel_reg;
    logic wr;

    logic signed [COORD_W:0] sx, sy, wx, wy, ex, ey, ax_s, ay_s;
    logic [COORD_W:0] ma, mb;
    logic [IDX_W-1:0] segc;

    always_comb
    begin
        if (count_reg < 9'd2) limit = 8'd1;
        else if (count_reg > 9'(DEPTH)) limit = 8'd255;
        else limit = 8'(count_reg - 9'd1);
    end

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    always_comb
    begin
        unique case (paddr[2])
            REG_COUNT:  prdata = {23'd0, count_reg};
            REG_RADIUS: prdata = {1'b0, radius_reg};
            default:    prdata = '0;
        endcase
    end

    assign sx = (COORD_W+1)'(rx1_reg) - (COORD_W+1)'(rx0_reg);
    assign sy = (COORD_W+1)'(ry1_reg) - (COORD_W+1)'(ry0_reg);
    assign wx = (COORD_W+1)'(rx0_reg) - (COORD_W+1)'(x_reg);
    assign wy = (COORD_W+1)'(ry0_reg) - (COORD_W+1)'(y_reg);
    assign ex = (COORD_W+1)'(x_reg) - (COORD_W+1)'(prev_x_reg);
    assign ey = (COORD_W+1)'(y_reg) - (COORD_W+1)'(prev_y_reg);
    assign ax_s = (COORD_W+1)'(rx1_reg) - (COORD_W+1)'(x_reg);
    assign ay_s = (COORD_W+1)'(ry1_reg) - (COORD_W+1)'(y_reg);

    function automatic logic [COORD_W:0] absv(input logic signed [COORD_W:0] v);
        absv = v[COORD_W] ? (COORD_W+1)'(-v) : v;
    endfunction

    function automatic logic [5:0] shn_w(input logic [COORD_W:0] p, input logic [COORD_W:0] q);
        shn_w = (p[COORD_W] || q[COORD_W]) ? 6'd2
              : ((p[COORD_W-1] || q[COORD_W-1]) ? 6'd1 : 6'd0);
    endfunction

    always_comb
    begin
        unique case (msel_reg)
            MS_WX_DY: begin mul_a = 46'(wx); mul_b = dir_y_reg; end
            MS_WY_DX: begin mul_a = 46'(wy); mul_b = dir_x_reg; end
            MS_EX_DX: begin mul_a = 46'(ex); mul_b = dir_x_reg; end
            MS_EY_DY: begin mul_a = 46'(ey); mul_b = dir_y_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    tldc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    assign sq_in = {32'd0, a_reg} * {32'd0, a_reg} + {32'd0, b_reg} * {32'd0, b_reg};
    tldc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(ctl.start_sqrt), .radicand(sq_in),
                      .done(sq_done), .root(sq_root));
    tldc_div u_div (.clk(clk), .rst_n(rst_n), .start(ctl.start_div), .dividend(dv_in),
                    .divisor(len_reg), .done(dv_done), .quotient(dv_q));

    assign ctl.start_sqrt = (state_reg == ST_LEN) || (state_reg == ST_DEVH)
                            || (state_reg == ST_TRV);
    assign ctl.start_div  = (state_reg == ST_DX) || (state_reg == ST_DY);
    assign dv_in = (state_reg == ST_DX)
                   ? SUM_W'({a_reg, 16'd0}) + SUM_W'(len_reg >> 1)
                   : SUM_W'({b_reg, 16'd0}) + SUM_W'(len_reg >> 1);

    assign segc = (seg_reg > limit) ? limit : seg_reg;

    logic [63:0] hm;
    logic [SUM_W-1:0] hv, dsum, tsum, dsum_p;
    logic signed [WIDE_W-1:0] pr_sum, pr_abs, pr_r;
    logic signed [SUM_W+1:0] psum;
    logic signed [SUM_W+2:0] csum;
    logic [61:0] r2;
    logic [5:0] shn;
    logic [COORD_W:0] mma, mmb;
    logic signed [WIDE_W-1:0] dv_raw, dv_abs;
    logic [SUM_W-1:0] dv_val;

    assign hm = {32'd0, sq_root} << sh_reg;
    assign hv = hm[SUM_W-1:0];
    assign r2 = {31'd0, radius_reg} * {31'd0, radius_reg};
    assign mma = absv(ax_s);
    assign mmb = absv(ay_s);

    assign dv_raw = acc_reg - mul_p;
    assign dv_abs = dv_raw[WIDE_W-1] ? -dv_raw : dv_raw;
    assign dv_val = SUM_W'((dv_abs + 64'sd32768) >>> 16);

    assign dsum   = (hv > SUM_MAX - dev_reg) ? SUM_MAX : dev_reg + hv;
    assign dsum_p = (dv_val > SUM_MAX - dev_reg) ? SUM_MAX : dev_reg + dv_val;
    assign tsum   = (hv > SUM_MAX - trv_reg) ? SUM_MAX : trv_reg + hv;

    always_comb
    begin
        pr_sum = acc_reg + mul_p;
        pr_abs = pr_sum[WIDE_W-1] ? -pr_sum : pr_sum;
        pr_r   = (pr_abs + 64'sd32768) >>> 16;
        if (pr_sum[WIDE_W-1]) pr_r = -pr_r;
        psum = (SUM_W+2)'(prog_reg) + (SUM_W+2)'(pr_r);
        if (psum > (SUM_W+2)'(PROG_MAX)) psum = (SUM_W+2)'(PROG_MAX);
        if (psum < (SUM_W+2)'(PROG_MIN)) psum = (SUM_W+2)'(PROG_MIN);
        csum = (SUM_W+3)'(dev_reg) + (SUM_W+3)'(trv_reg) - (SUM_W+3)'(psum);
        if (csum < 0) cost_next = '0;
        else if (csum > $signed({4'd0, COST_MAX})) cost_next = COST_MAX;
        else cost_next = COST_W'(csum);
    end

    always_comb
    begin
        shn = '0;
        if (ma[COORD_W] || mb[COORD_W]) shn = 6'd2;
        else if (ma[COORD_W-1] || mb[COORD_W-1]) shn = 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE)
        begin
            path_x[s_axis_tdata[7:0]] <= s_axis_tdata[39:8];
            path_y[s_axis_tdata[7:0]] <= s_axis_tdata[71:40];
        end
        rx1_reg <= path_x[seg_reg];
        ry1_reg <= path_y[seg_reg];
        rx0_reg <= path_x[8'(seg_reg - 8'd1)];
        ry0_reg <= path_y[8'(seg_reg - 8'd1)];
    end

    assign ma = absv(sx);
    assign mb = absv(sy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 9'd2;
            radius_reg <= 31'd131072;
            seg_reg <= 8'd1;
            prev_x_reg <= '0; prev_y_reg <= '0;
            dir_x_reg <= '0; dir_y_reg <= '0;
            dev_reg <= '0; trv_reg <= '0; prog_reg <= '0;
            m_valid_reg <= 1'b0;
            msel_reg <= MS_NONE;
            x_reg <= '0; y_reg <= '0;
            first_reg <= 1'b0; last_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; sh_reg <= '0; len_reg <= '0;
            acc_reg <= '0; cost_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                if (paddr[2] == REG_COUNT) count_reg <= pwdata[CNT_W-1:0];
                else radius_reg <= pwdata[RAD_W-1:0];
            end
            unique case (state_reg)
                ST_IDLE:
                if (s_axis_tvalid && s_axis_tuser == OP_POINT)
                begin
                    x_reg <= s_axis_tdata[39:8];
                    y_reg <= s_axis_tdata[71:40];
                    first_reg <= s_axis_tdata[72];
                    last_reg <= s_axis_tdata[73];
                    if (s_axis_tdata[72]) seg_reg <= segc;
                    state_reg <= ST_RD;
                end
                ST_RD: state_reg <= first_reg ? ST_ARR : ST_W;
                ST_ARR:
                begin
                    if (!mma[COORD_W] && !mma[COORD_W-1] && !mmb[COORD_W]
                        && !mmb[COORD_W-1]
                        && (64'(mma) * 64'(mma) + 64'(mmb) * 64'(mmb) < 64'(r2))
                        && seg_reg < limit)
                        seg_reg <= seg_reg + 8'd1;
                    state_reg <= ST_SEG;
                end
                ST_SEG: state_reg <= ST_NORM;
                ST_NORM:
                begin
                    dev_reg <= '0; trv_reg <= '0; prog_reg <= '0;
                    prev_x_reg <= x_reg; prev_y_reg <= y_reg;
                    if (ma == '0 && mb == '0)
                    begin
                        dir_x_reg <= '0; dir_y_reg <= '0;
                        state_reg <= ST_W;
                    end
                    else
                    begin
                        a_reg <= 32'(ma >> shn);
                        b_reg <= 32'(mb >> shn);
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN:
                if (!a_reg[30] && !b_reg[30])
                begin
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg << 1;
                end
                else state_reg <= ST_LENW;
                ST_LENW:
                if (sq_done)
                begin
                    len_reg <= sq_root;
                    state_reg <= ST_DX;
                end
                ST_DX: state_reg <= ST_DXW;
                ST_DXW:
                if (dv_done)
                begin
                    dir_x_reg <= sx[COORD_W] ? DIR_W'(-$signed({1'b0, dv_q[DIR_W-2:0]}))
                                             : DIR_W'(dv_q);
                    state_reg <= ST_DY;
                end
                ST_DY: state_reg <= ST_DYW;
                ST_DYW:
                if (dv_done)
                begin
                    dir_y_reg <= sy[COORD_W] ? DIR_W'(-$signed({1'b0, dv_q[DIR_W-2:0]}))
                                             : DIR_W'(dv_q);
                    state_reg <= ST_W;
                end
                ST_W:
                begin
                    if (dir_x_reg == '0 && dir_y_reg == '0)
                    begin
                        a_reg <= 32'(absv(wx) >> shn_w(absv(wx), absv(wy)));
                        b_reg <= 32'(absv(wy) >> shn_w(absv(wx), absv(wy)));
                        sh_reg <= shn_w(absv(wx), absv(wy));
                        state_reg <= ST_DEVH;
                    end
                    else
                    begin
                        msel_reg <= MS_WX_DY;
                        state_reg <= ST_DEV1;
                    end
                end
                ST_DEV1:
                begin
                    msel_reg <= MS_WY_DX;
                    state_reg <= ST_DEV2;
                end
                ST_DEV2:
                begin
                    acc_reg <= mul_p;
                    msel_reg <= MS_NONE;
                    state_reg <= ST_DEVHW;
                end
                ST_DEVH: state_reg <= ST_DEVHW;
                ST_DEVHW:
                if (dir_x_reg != '0 || dir_y_reg != '0)
                begin
                    dev_reg <= dsum_p;
                    sh_reg <= shn_w(absv(ex), absv(ey));
                    a_reg <= 32'(absv(ex) >> shn_w(absv(ex), absv(ey)));
                    b_reg <= 32'(absv(ey) >> shn_w(absv(ex), absv(ey)));
                    state_reg <= ST_TRV;
                end
                else if (sq_done)
                begin
                    dev_reg <= dsum;
                    sh_reg <= shn_w(absv(ex), absv(ey));
                    a_reg <= 32'(absv(ex) >> shn_w(absv(ex), absv(ey)));
                    b_reg <= 32'(absv(ey) >> shn_w(absv(ex), absv(ey)));
                    state_reg <= ST_TRV;
                end
                ST_TRV: state_reg <= ST_TRVW;
                ST_TRVW:
                if (sq_done)
                begin
                    trv_reg <= tsum;
                    msel_reg <= MS_EX_DX;
                    state_reg <= ST_PR1;
                end
                ST_PR1:
                begin
                    msel_reg <= MS_EY_DY;
                    state_reg <= ST_PR2;
                end
                ST_PR2:
                begin
                    acc_reg <= mul_p;
                    msel_reg <= MS_NONE;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    prev_x_reg <= x_reg; prev_y_reg <= y_reg;
                    if (last_reg)
                    begin
                        cost_reg <= cost_next;
                        dev_reg <= '0; trv_reg <= '0; prog_reg <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        prog_reg <= SUM_W'(psum);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                if (m_axis_tready)
                begin
                    m_valid_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, seg_reg, cost_reg};
endmodule

// ===== sv/tldc_sqrt.sv =====
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Depends on tldc_pkg.
`timescale 1ns / 1ps
module tldc_sqrt
    import tldc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [WIDE_W-1:0]   radicand,
    output logic                done,
    output logic [WIDE_W/2-1:0] root
);
    logic [WIDE_W-1:0]   rem_reg, rem_next;
    logic [WIDE_W/2-1:0] root_reg, root_next;
    logic [WIDE_W-1:0]   val_reg, val_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next, done_reg, done_next;
    logic [WIDE_W+1:0]   trial;
    logic [WIDE_W+1:0]   rem_sh;

    always_comb
    begin
        rem_sh = {rem_reg, val_reg[WIDE_W-1 -: 2]};
        trial  = {{(WIDE_W/2){1'b0}}, root_reg, 2'b01};
        rem_next = rem_reg; root_next = root_reg; val_next = val_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start)
        begin
            rem_next = '0; root_next = '0; val_next = radicand;
            cnt_next = '0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[WIDE_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = WIDE_W'(rem_sh - trial);
                root_next = {root_reg[WIDE_W/2-2:0], 1'b1};
            end
            else
            begin
                rem_next  = WIDE_W'(rem_sh);
                root_next = {root_reg[WIDE_W/2-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(WIDE_W/2-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== sv/tldc_div.sv =====
// Iterative restoring divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on tldc_pkg.
`timescale 1ns / 1ps
module tldc_div
    import tldc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [31:0]       divisor,
    output logic              done,
    output logic [SUM_W-1:0]  quotient
);
    logic [32:0]      rem_reg, rem_next;
    logic [SUM_W-1:0] q_reg, q_next;
    logic [31:0]      d_reg, d_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [33:0]      sh;

    always_comb
    begin
        sh = {rem_reg, q_reg[SUM_W-1]};
        rem_next = rem_reg; q_next = q_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start)
        begin
            rem_next = '0; q_next = dividend; d_next = divisor;
            cnt_next = '0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {2'b00, d_reg})
            begin
                rem_next = 33'(sh - {2'b00, d_reg});
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = 33'(sh);
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(SUM_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ===== sv/tldc_mul.sv =====
// Shared signed 46x18 multiplier, product registered.
// Depends on tldc_pkg.
`timescale 1ns / 1ps
module tldc_mul
    import tldc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [45:0]       a,
    input  logic signed [DIR_W-1:0]  b,
    output logic signed [WIDE_W-1:0] p
);
    logic signed [WIDE_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= WIDE_W'(a * b);
    end

    assign p = p_reg;
endmodule

// ===== sv/tldc_check.sv =====
// Port checker for the trajectory line deviation cost block, bound to the top level.
// Depends on trajectory_line_deviation_cost_core ports only.
`timescale 1ns / 1ps
module tldc_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result waits");
    a_seg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[54:47] != 8'd0)
        else $error("segment end zero");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[55])
        else $error("pad bit set");
endmodule

bind trajectory_line_deviation_cost_core tldc_check u_check (.*);
